// ===== rtl/lgpc_pkg.sv =====
`default_nettype none
package lgpc_pkg;

    // defaults for the top-level parameters
    localparam int MAX_GROUPS_DEF = 64;
    localparam int VALUE_BITS_DEF = 30;

    // fixed field widths
    localparam int SPAN_BITS = 30;
    localparam int CFG_BITS  = 7;

    typedef struct packed {
        logic [SPAN_BITS-1:0] height;
        logic                 last_item;
    } t_in;

    typedef struct packed {
        logic [SPAN_BITS-1:0] total_span;
        logic                 order_error;
    } t_out;

    // broadcast controls for the gap chain
    typedef struct packed {
        logic pop;    // shift every entry one place toward the head
        logic clear;  // zero every entry and carry
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_SUM
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/largest_gaps_partition_cost_unit.sv =====
`default_nettype none
// Minimum summed span of a sorted run split into k contiguous groups. Values
// stream in one transaction per cycle; each adjacent gap enters a systolic
// chain of MAX_GROUPS-1 cells that keeps the largest gaps in descending order,
// one compare-and-swap per cell per cycle. The transaction with last_item set
// closes the run: the input then stalls while the chain settles (until no
// gap is in flight) and while the head is popped k-1 times to add up the kept
// gaps and the result register is loaded. The result is total_span =
// (sum of gaps) - (kept gaps), floored at zero, with order_error set if any
// value fell below its predecessor (such a gap counts as zero). The gap total
// saturates at the VALUE_BITS maximum. The result waits in its own register,
// so the next run streams in meanwhile; a run that closes while the previous
// result is still stalled holds its sum (input stalled) until that register
// empties.
// k_groups is sampled from i_cfg_wdata when i_cfg_we is high; 0 acts as 1 and
// values above MAX_GROUPS act as MAX_GROUPS. Write it only while idle.
module largest_gaps_partition_cost_unit #(
    parameter int MAX_GROUPS = lgpc_pkg::MAX_GROUPS_DEF,
    parameter int VALUE_BITS = lgpc_pkg::VALUE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration
    input  wire                            i_cfg_we,
    input  wire  [lgpc_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    // input channel
    input  wire                            i_in_valid,
    input  wire lgpc_pkg::t_in             i_in,
    output logic                           o_in_stall,
    // result channel
    output logic                           o_out_valid,
    output lgpc_pkg::t_out                 o_out,
    input  wire                            i_out_stall
);

    localparam int CW = $clog2(MAX_GROUPS);          // holds 0..MAX_GROUPS-1
    localparam int KW = (lgpc_pkg::CFG_BITS > CW + 1) ? lgpc_pkg::CFG_BITS : CW + 1;
    localparam int KB = VALUE_BITS + CW;             // kept-gap accumulator
    localparam int XB = VALUE_BITS + lgpc_pkg::SPAN_BITS;

    // ---------------- registers ----------------
    lgpc_pkg::t_state              r_state;
    lgpc_pkg::t_state              n_state;
    logic [lgpc_pkg::CFG_BITS-1:0] r_k_groups;
    logic                          r_seen;
    logic                          r_err;
    logic [VALUE_BITS-1:0]         r_prev;
    logic [VALUE_BITS-1:0]         r_total;
    logic [KB-1:0]                 r_kept;
    logic [CW-1:0]                 r_cnt;
    lgpc_pkg::t_out                r_out;
    logic                          r_out_valid;

    // ---------------- combinational ----------------
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_out_free;  // result register empty
    logic                  w_load;      // sum finished and result register free
    logic [XB-1:0]         w_hx;
    logic [VALUE_BITS-1:0] w_h;
    logic                  w_drop;      // value below its predecessor
    logic [VALUE_BITS-1:0] w_gap;
    logic [VALUE_BITS:0]   w_sum;
    logic [VALUE_BITS-1:0] w_total_sat;
    logic [KW-1:0]         w_k;
    logic [CW-1:0]         w_cuts;
    logic                  w_sum_done;
    logic [KB-1:0]         w_total_ext;
    logic [KB-1:0]         w_diff;
    logic [XB-1:0]         w_costx;
    logic [VALUE_BITS-1:0] w_head;
    logic                  w_busy;
    lgpc_pkg::t_chain_ctl  w_ctl;
    logic [VALUE_BITS-1:0] w_chain_gap;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = o_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid;

    // height masked or zero-extended to the internal value width
    assign w_hx = {{VALUE_BITS{1'b0}}, i_in.height};
    assign w_h  = w_hx[VALUE_BITS-1:0];

    assign w_drop = r_seen && (w_h < r_prev);
    assign w_gap  = (r_seen && !w_drop) ? (w_h - r_prev) : '0;
    assign w_sum  = {1'b0, r_total} + {1'b0, w_gap};
    assign w_total_sat = w_sum[VALUE_BITS] ? '1 : w_sum[VALUE_BITS-1:0];

    // number of cuts: clamp k to 1..MAX_GROUPS, minus one
    assign w_k = KW'(r_k_groups);
    always_comb begin
        if (w_k == '0) begin
            w_cuts = '0;
        end else if (w_k > KW'(MAX_GROUPS)) begin
            w_cuts = CW'(MAX_GROUPS - 1);
        end else begin
            w_cuts = CW'(w_k - KW'(1));
        end
    end

    assign w_sum_done  = (r_cnt == w_cuts);
    assign w_load      = (r_state == lgpc_pkg::ST_SUM) && w_sum_done && w_out_free;
    assign w_total_ext = KB'(r_total);
    assign w_diff      = (w_total_ext >= r_kept) ? (w_total_ext - r_kept) : '0;
    assign w_costx     = {{lgpc_pkg::SPAN_BITS{1'b0}}, w_diff[VALUE_BITS-1:0]};

    assign w_chain_gap = w_in_acc ? w_gap : '0;

    lgpc_chain #(
        .MAX_GROUPS(MAX_GROUPS),
        .VALUE_BITS(VALUE_BITS)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_gap  (w_chain_gap),
        .o_head (w_head),
        .o_busy (w_busy)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgpc_pkg::ST_IDLE: begin
                if (w_in_acc && i_in.last_item) begin
                    n_state = lgpc_pkg::ST_SETTLE;
                end
            end
            lgpc_pkg::ST_SETTLE: begin
                if (!w_busy) begin
                    n_state = lgpc_pkg::ST_SUM;
                end
            end
            lgpc_pkg::ST_SUM: begin
                // leave only once the result register can take the cost
                if (w_sum_done && w_out_free) begin
                    n_state = lgpc_pkg::ST_IDLE;
                end
            end
            default: n_state = lgpc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_in_stall  = 1'b1;
        w_ctl       = '0;
        case (r_state)
            lgpc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            lgpc_pkg::ST_SETTLE: begin
                w_ctl = '0;
            end
            lgpc_pkg::ST_SUM: begin
                // pop while cuts remain, then wipe the chain as the cost is loaded
                w_ctl.pop   = !w_sum_done;
                w_ctl.clear = w_sum_done && w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgpc_pkg::ST_IDLE;
            r_k_groups  <= lgpc_pkg::CFG_BITS'(1);
            r_seen      <= 1'b0;
            r_err       <= 1'b0;
            r_prev      <= '0;
            r_total     <= '0;
            r_kept      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_k_groups <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_seen  <= 1'b1;
                r_prev  <= w_h;
                r_err   <= r_err | w_drop;
                r_total <= w_total_sat;
            end
            if (r_state == lgpc_pkg::ST_SUM) begin
                if (!w_sum_done) begin
                    r_kept <= r_kept + KB'(w_head);
                    r_cnt  <= r_cnt + CW'(1);
                end else if (w_out_free) begin
                    // run closed: clear run state
                    r_seen  <= 1'b0;
                    r_err   <= 1'b0;
                    r_prev  <= '0;
                    r_total <= '0;
                    r_kept  <= '0;
                    r_cnt   <= '0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded as the run closes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.total_span  <= w_costx[lgpc_pkg::SPAN_BITS-1:0];
            r_out.order_error <= r_err;
        end
    end

    // ---------------- assertions ----------------
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result dropped or changed");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> !o_out_valid)
        else $error("result repeated after its transaction");

    a_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgpc_pkg::ST_SETTLE || r_state == lgpc_pkg::ST_SUM) |-> r_seen)
        else $error("run state lost before the result");

    a_pop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgpc_pkg::ST_SUM) |-> (r_cnt <= w_cuts))
        else $error("popped more gaps than cuts");

endmodule
`default_nettype wire

// ===== rtl/lgpc_cell.sv =====
`default_nettype none
module lgpc_cell #(
    parameter int VALUE_BITS = lgpc_pkg::VALUE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire lgpc_pkg::t_chain_ctl i_ctl,
    input  wire  [VALUE_BITS-1:0]     i_carry,  // gap handed down from the left
    input  wire  [VALUE_BITS-1:0]     i_next,   // right neighbor's entry, for pop
    output logic [VALUE_BITS-1:0]     o_val,
    output logic [VALUE_BITS-1:0]     o_carry
);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_carry;
    logic [VALUE_BITS-1:0] n_val;
    logic [VALUE_BITS-1:0] n_carry;

    // clear zeroes, pop takes the right neighbor's entry; else keep the larger, pass the smaller on
    always_comb begin
        if (i_ctl.clear) begin
            n_val   = '0;
            n_carry = '0;
        end else if (i_ctl.pop) begin
            n_val   = i_next;
            n_carry = '0;
        end else if (i_carry > r_val) begin
            n_val   = i_carry;
            n_carry = r_val;
        end else begin
            n_val   = r_val;
            n_carry = i_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val   <= '0;
            r_carry <= '0;
        end else begin
            r_val   <= n_val;
            r_carry <= n_carry;
        end
    end

    assign o_val   = r_val;
    assign o_carry = r_carry;

endmodule
`default_nettype wire

// ===== rtl/lgpc_chain.sv =====
`default_nettype none
module lgpc_chain #(
    parameter int MAX_GROUPS = lgpc_pkg::MAX_GROUPS_DEF,
    parameter int VALUE_BITS = lgpc_pkg::VALUE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire lgpc_pkg::t_chain_ctl i_ctl,
    input  wire  [VALUE_BITS-1:0]     i_gap,   // zero when nothing is inserted
    output logic [VALUE_BITS-1:0]     o_head,  // largest kept gap
    output logic                      o_busy   // a gap is still moving down
);

    localparam int DEPTH = MAX_GROUPS - 1;

    logic [VALUE_BITS-1:0] r_gap_in;
    logic [VALUE_BITS-1:0] w_val   [DEPTH+1];
    logic [VALUE_BITS-1:0] w_carry [DEPTH+1];
    logic [DEPTH:0]        w_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_in <= '0;
        end else begin
            r_gap_in <= i_gap;
        end
    end

    assign w_carry[0]  = r_gap_in;
    assign w_val[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lgpc_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (i_ctl),
            .i_carry(w_carry[g]),
            .i_next (w_val[g+1]),
            .o_val  (w_val[g]),
            .o_carry(w_carry[g+1])
        );
    end

    // the carry out of the last cell is a gap too small to keep
    for (genvar g = 0; g <= DEPTH; g++) begin : g_live
        assign w_live[g] = |w_carry[g];
    end

    assign o_head = w_val[0];
    assign o_busy = |w_live;

endmodule
`default_nettype wire
